@@ rtl/core/kvpd_pkg.sv @@
package kvpd_pkg;

  // field widths fixed by the packet format
  localparam int KIND_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 32;
  localparam int LEN_BYTES  = LEN_W / BYTE_W;
  localparam int DEF_VALUE_LENGTH_BYTES = 4;

  // byte kind codes
  localparam logic [KIND_W-1:0] KIND_MARKER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TYPE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ID     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_KLEN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_KEY    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_VLEN   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_VALUE  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_TERM   = 3'd7;

  // parse phase, one-hot
  typedef enum logic [7:0] {
    PH_MARKER = 8'b0000_0001,
    PH_TYPE   = 8'b0000_0010,
    PH_ID     = 8'b0000_0100,
    PH_KLEN   = 8'b0000_1000,
    PH_KEY    = 8'b0001_0000,
    PH_VLEN   = 8'b0010_0000,
    PH_VALUE  = 8'b0100_0000,
    PH_TERM   = 8'b1000_0000
  } phase_t;

  // one classified byte
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic [LEN_W-1:0]  pos;
    logic [BYTE_W-1:0] klen;
    logic [LEN_W-1:0]  vlen;
    logic              fend;
    logic              rend;
    logic              trunc;
  } result_t;

  // kind code of a phase
  function automatic logic [KIND_W-1:0] kind_of(input phase_t ph);
    logic [KIND_W-1:0] k;
    case (ph)
      PH_MARKER: k = KIND_MARKER;
      PH_TYPE:   k = KIND_TYPE;
      PH_ID:     k = KIND_ID;
      PH_KLEN:   k = KIND_KLEN;
      PH_KEY:    k = KIND_KEY;
      PH_VLEN:   k = KIND_VLEN;
      PH_VALUE:  k = KIND_VALUE;
      PH_TERM:   k = KIND_TERM;
      default:   k = KIND_MARKER;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/kvpd_parser.sv @@
module kvpd_parser
  import kvpd_pkg::*;
#(
  parameter int VALUE_LENGTH_BYTES = DEF_VALUE_LENGTH_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_packet,
  output result_t           res
);

  localparam int IDX_W = (VALUE_LENGTH_BYTES > 1) ? $clog2(VALUE_LENGTH_BYTES) : 1;

  phase_t             phase, phase_next, goto;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [BYTE_W-1:0]  key_len, key_len_next;
  logic [LEN_W-1:0]   val_len, val_len_next;
  logic [LEN_W-1:0]   idx_ext, idx_inc, left_dec;
  logic [1:0]         lane;
  logic [LEN_W-1:0]   pos;
  logic               fend, rend;

  assign idx_ext  = LEN_W'(idx);
  assign idx_inc  = idx_ext + LEN_W'(1);
  assign lane     = idx_ext[1:0];
  assign left_dec = bytes_left - LEN_W'(1);

  // next state and classification of the current byte
  always_comb begin
    bytes_left_next = bytes_left;
    idx_next        = idx;
    key_len_next    = key_len;
    val_len_next    = val_len;
    goto            = PH_MARKER;
    pos             = '0;
    fend            = 1'b1;
    rend            = 1'b0;
    case (phase)
      PH_MARKER: begin
        key_len_next = '0;
        val_len_next = '0;
        goto         = PH_TYPE;
      end
      PH_TYPE: begin
        goto = PH_ID;
      end
      PH_ID: begin
        goto = PH_KLEN;
      end
      PH_KLEN: begin
        key_len_next    = data_byte;
        val_len_next    = '0;
        idx_next        = '0;
        bytes_left_next = LEN_W'(data_byte);
        goto            = (data_byte == '0) ? PH_VLEN : PH_KEY;
      end
      PH_KEY: begin
        pos             = LEN_W'(key_len - bytes_left[BYTE_W-1:0]);
        bytes_left_next = left_dec;
        fend            = (left_dec == '0);
        goto            = fend ? PH_VLEN : PH_KEY;
      end
      PH_VLEN: begin
        pos = idx_ext;
        // only the first four length bytes land in the 32-bit length
        if (idx_ext < LEN_W'(LEN_BYTES)) begin
          val_len_next[lane*BYTE_W +: BYTE_W] = val_len[lane*BYTE_W +: BYTE_W] | data_byte;
        end
        fend = (idx_inc >= LEN_W'(VALUE_LENGTH_BYTES));
        if (fend) begin
          idx_next        = '0;
          bytes_left_next = val_len_next;
          goto            = (val_len_next == '0) ? PH_TERM : PH_VALUE;
        end else begin
          idx_next = IDX_W'(idx_inc);
          goto     = PH_VLEN;
        end
      end
      PH_VALUE: begin
        pos             = val_len - bytes_left;
        bytes_left_next = left_dec;
        fend            = (left_dec == '0);
        goto            = fend ? PH_TERM : PH_VALUE;
      end
      PH_TERM: begin
        rend = 1'b1;
        goto = PH_KLEN;
      end
      default: begin
        goto = PH_MARKER;
      end
    endcase

    // end of packet returns to the marker and clears the counters
    if (end_of_packet) begin
      phase_next      = PH_MARKER;
      bytes_left_next = '0;
      idx_next        = '0;
    end else begin
      phase_next = goto;
    end

    res.kind  = kind_of(phase);
    res.value = data_byte;
    res.pos   = pos;
    res.klen  = key_len_next;
    res.vlen  = val_len_next;
    res.fend  = fend;
    res.rend  = rend;
    res.trunc = end_of_packet && (goto != PH_KLEN);
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MARKER;
      bytes_left <= '0;
      idx        <= '0;
      key_len    <= '0;
      val_len    <= '0;
    end else if (step) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      idx        <= idx_next;
      key_len    <= key_len_next;
      val_len    <= val_len_next;
    end
  end

`ifndef SYNTHESIS
  // a byte marked end of packet always leaves the parser at a marker
  assert property (@(posedge clk) disable iff (rst)
    step && end_of_packet |=> phase == PH_MARKER && bytes_left == '0 && idx == '0)
    else $error("parser not back at marker after end of packet");

  // inside a key there is at least one byte left, no more than the key length
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_KEY |-> bytes_left != '0 && bytes_left <= LEN_W'(key_len))
    else $error("key byte count out of range");

  // inside a value there is at least one byte left, no more than the value length
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_VALUE |-> bytes_left != '0 && bytes_left <= val_len)
    else $error("value byte count out of range");
`endif

endmodule

@@ rtl/core/key_value_packet_deframer.sv @@
// A request accepted into the input register moves into the result register once the
// output is free to take it, and is offered there until it is taken with out_ready.
// Throughput: one byte per cycle when the output is not stalled; one parse update per byte.
// A stalled output holds its result while one more request waits in the input register.
// Reset (rst, synchronous, active high) empties both registers and returns the parser
// to expecting a marker byte with all lengths and counters at zero.
module key_value_packet_deframer
  import kvpd_pkg::*;
#(
  parameter int VALUE_LENGTH_BYTES = DEF_VALUE_LENGTH_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_packet,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] byte_kind,
  output logic [BYTE_W-1:0] byte_value,
  output logic [LEN_W-1:0]  position_in_field,
  output logic [BYTE_W-1:0] key_length,
  output logic [LEN_W-1:0]  value_length,
  output logic              field_end,
  output logic              record_end,
  output logic              truncated
);

  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              stage_eop;
  logic              advance;
  result_t           res;
  result_t           out_res;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= data_byte;
      stage_eop  <= end_of_packet;
    end
  end

  // byte classification and parse state
  kvpd_parser #(
    .VALUE_LENGTH_BYTES(VALUE_LENGTH_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .data_byte    (stage_byte),
    .end_of_packet(stage_eop),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign byte_kind         = out_res.kind;
  assign byte_value        = out_res.value;
  assign position_in_field = out_res.pos;
  assign key_length        = out_res.klen;
  assign value_length      = out_res.vlen;
  assign field_end         = out_res.fend;
  assign record_end        = out_res.rend;
  assign truncated         = out_res.trunc;

endmodule
